// ===== hw/rtl/pls_pkg.sv =====
// pls_pkg: shared types and codes for the positional list store.
// Used by pls_cell and positional_list_store; no dependencies.
package pls_pkg;

  // Request mode field values.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

endpackage

// ===== hw/rtl/pls_cell.sv =====
// pls_cell: one storage cell of the list chain.
// Shifts from its left or right neighbor, loads new data, or holds; uses pls_pkg.
module pls_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int POS_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  pls_pkg::cell_op_t     op,
  input  logic [POS_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic [DATA_WIDTH-1:0] left_d,
  input  logic [DATA_WIDTH-1:0] right_d,
  output logic [DATA_WIDTH-1:0] q
);

  // 1-based position this cell holds
  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op)
      pls_pkg::OP_INSERT: begin
        if (MY_POS > pos) begin
          data_nxt = left_d;
        end else if (MY_POS == pos) begin
          data_nxt = ins_data;
        end
      end
      pls_pkg::OP_DELETE: begin
        if (MY_POS >= pos) begin
          data_nxt = right_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== hw/rtl/positional_list_store.sv =====
// positional_list_store: bounded ordered list with insert/delete at a 1-based position.
// The result of an accepted request is registered; throughput one transaction per cycle
// unless out_stall holds it, set by the chain of pls_cell stages all shifting in the same cycle.
// Synchronous active-low reset clears the entry count and output valid; the
// cell contents are not reset and are only read once written.
// Depends on pls_pkg and pls_cell.
module positional_list_store #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [4:0]         out_length
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  pls_pkg::status_t      status_r;
  logic signed [31:0]    removed_r;
  logic [4:0]            length_r;

  logic                  accept;
  logic [POS_W-1:0]      pos_ext;
  logic [POS_W-1:0]      cnt_ext;
  pls_pkg::status_t      status;
  pls_pkg::cell_op_t     op;
  logic [DATA_WIDTH-1:0] ins_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  // the output register frees as it drains, so a new request can land every cycle unless out_stall holds it
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pos_ext  = POS_W'(in_position);
  assign cnt_ext  = POS_W'(count_r);
  assign ins_data = DATA_WIDTH'($unsigned(in_value));

  always_comb begin
    status = pls_pkg::ST_OK;
    if (in_mode == pls_pkg::MODE_INSERT) begin
      // position checked before fullness
      if (pos_ext == '0 || pos_ext > cnt_ext + POS_W'(1)) begin
        status = pls_pkg::ST_BADPOS;
      end else if (count_r == FULL_CNT) begin
        status = pls_pkg::ST_FULL;
      end
    end else begin
      if (count_r == '0) begin
        status = pls_pkg::ST_EMPTY;
      end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
        status = pls_pkg::ST_BADPOS;
      end
    end
  end

  always_comb begin
    op        = pls_pkg::OP_HOLD;
    count_nxt = count_r;
    if (accept && status == pls_pkg::ST_OK) begin
      if (in_mode == pls_pkg::MODE_INSERT) begin
        op        = pls_pkg::OP_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end else begin
        op        = pls_pkg::OP_DELETE;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // entry at the requested position, for the delete result
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (POS_W'(i + 1) == pos_ext) begin
        rd_data = cell_q[i];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      // missing neighbors are tied to ins_data; the last cell takes it on a delete
      if (g == 0) begin : g_first
        assign left_d = ins_data;
      end else begin : g_mid_l
        assign left_d = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_d = ins_data;
      end else begin : g_mid_r
        assign right_d = cell_q[g+1];
      end

      pls_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .POS_W      (POS_W),
        .INDEX      (g)
      ) u_cell (
        .clk      (clk),
        .op       (op),
        .pos      (pos_ext),
        .ins_data (ins_data),
        .left_d   (left_d),
        .right_d  (right_d),
        .q        (cell_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status;
      length_r  <= 5'(count_nxt);
      if (op == pls_pkg::OP_DELETE) begin
        removed_r <= 32'(rd_data);
      end else begin
        removed_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_length        = length_r;

endmodule

// ===== bench/list_checker.sv =====
// list_checker: watches the request and result channels of positional_list_store,
// predicts each result from its own copy of the list and compares field by field.
// Depends on pls_pkg for the mode and status codes.
module list_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_position,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic signed [31:0] out_removed_value,
  input  logic [4:0]         out_length,
  output int                 error_count,
  output int                 results_outstanding
);

  typedef struct packed {
    pls_pkg::status_t status;
    logic [31:0]      removed_value;
    logic [4:0]       length;
  } list_result_t;

  logic signed [31:0] list_vals [LIST_DEPTH];
  int                 list_len;
  list_result_t       expected_results [$];

  initial begin
    error_count         = 0;
    results_outstanding = 0;
    list_len            = 0;
  end

  // Applies one request to the shadow list and returns the result it should produce.
  function automatic list_result_t apply_request(logic mode, logic signed [31:0] value,
                                                 logic [4:0] position);
    list_result_t r;
    int           pos;
    int           k;
    pos             = int'(position);
    r.status        = pls_pkg::ST_OK;
    r.removed_value = '0;
    if (mode == pls_pkg::MODE_INSERT) begin
      if (pos == 0 || pos > list_len + 1) begin
        r.status = pls_pkg::ST_BADPOS;
      end else if (list_len >= LIST_DEPTH) begin
        r.status = pls_pkg::ST_FULL;
      end else begin
        for (k = list_len; k > pos - 1; k--) list_vals[k] = list_vals[k - 1];
        list_vals[pos - 1] = value;
        list_len++;
      end
    end else begin
      if (list_len == 0) begin
        r.status = pls_pkg::ST_EMPTY;
      end else if (pos == 0 || pos > list_len) begin
        r.status = pls_pkg::ST_BADPOS;
      end else begin
        r.removed_value = list_vals[pos - 1];
        for (k = pos - 1; k + 1 < list_len; k++) list_vals[k] = list_vals[k + 1];
        list_len--;
      end
    end
    r.length = list_len[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      // Result side first: the result is registered, so a result seen at this edge
      // always belongs to an earlier request.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            error_count++;
          end
          if (out_removed_value !== exp_r.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   $signed(exp_r.removed_value), out_removed_value);
            error_count++;
          end
          if (out_length !== exp_r.length) begin
            $error("length: expected %0d, got %0d", exp_r.length, out_length);
            error_count++;
          end
        end
      end
      if (in_valid && in_stall === 1'b0)
        expected_results.push_back(apply_request(in_mode, in_value, in_position));
    end
    results_outstanding <= expected_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// testbench: drives directed and random insert/delete requests into positional_list_store
// with random idling on both channels; list_checker predicts and compares the results.
// Depends on pls_pkg, positional_list_store and list_checker.
module testbench;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_REQS = 400;

  logic               clk               = 1'b0;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_stall;
  logic               in_mode           = pls_pkg::MODE_INSERT;
  logic signed [31:0] in_value          = '0;
  logic [4:0]         in_position       = '0;
  logic               out_valid;
  logic               out_stall         = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_removed_value;
  logic [4:0]         out_length;

  int   error_count;
  int   results_outstanding;
  int   cycle_count = 0;
  int   fill        = 0;   // list length as seen by the request generator
  logic calm        = 1'b0;

  always #5 clk = ~clk;

  positional_list_store #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (32)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_length        (out_length)
  );

  list_checker #(
    .LIST_DEPTH (LIST_DEPTH)
  ) checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_value            (in_value),
    .in_position         (in_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_removed_value   (out_removed_value),
    .out_length          (out_length),
    .error_count         (error_count),
    .results_outstanding (results_outstanding)
  );

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 31);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic mode, input logic signed [31:0] value,
                              input logic [4:0] position);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_value    <= value;
    in_position <= position;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (mode == pls_pkg::MODE_INSERT) begin
      if (position >= 1 && position <= fill + 1 && fill < LIST_DEPTH) fill++;
    end else begin
      if (fill > 0 && position >= 1 && position <= fill) fill--;
    end
  endtask

  initial begin
    logic       mode;
    logic [4:0] position;
    int         insert_pct;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: deletes rejected as empty, bad insert positions, first insert.
    send_request(pls_pkg::MODE_DELETE, 32'sd5, 5'd1);
    send_request(pls_pkg::MODE_DELETE, 32'sd5, 5'd0);
    send_request(pls_pkg::MODE_INSERT, 32'sd9, 5'd0);
    send_request(pls_pkg::MODE_INSERT, 32'sd9, 5'd2);
    send_request(pls_pkg::MODE_INSERT, 32'sh8000_0000, 5'd1);
    send_request(pls_pkg::MODE_INSERT, 32'sh7fff_ffff, 5'd2);
    send_request(pls_pkg::MODE_INSERT, 32'sd0, 5'd1);
    send_request(pls_pkg::MODE_INSERT, -32'sd1, 5'd4);
    // Fill to capacity at random places.
    while (fill < LIST_DEPTH)
      send_request(pls_pkg::MODE_INSERT, random_value(), 5'($urandom_range(fill + 1, 1)));
    send_request(pls_pkg::MODE_INSERT, 32'sd7, 5'd17);   // full
    send_request(pls_pkg::MODE_INSERT, 32'sd7, 5'd18);   // position checked before full
    send_request(pls_pkg::MODE_INSERT, 32'sd7, 5'd31);
    send_request(pls_pkg::MODE_DELETE, 32'sd0, 5'd0);
    send_request(pls_pkg::MODE_DELETE, 32'sd0, 5'd17);
    send_request(pls_pkg::MODE_DELETE, 32'sd0, 5'd16);
    send_request(pls_pkg::MODE_DELETE, 32'sd0, 5'd1);

    // Random part: insert-heavy and delete-heavy stretches so the list swings
    // between empty and full; mostly legal positions, some garbage.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm       = (n >= 200 && n < 280);
      insert_pct = ((n / 40) % 2 == 0) ? 70 : 30;
      mode       = ($urandom_range(99) < insert_pct) ? pls_pkg::MODE_INSERT
                                                     : pls_pkg::MODE_DELETE;
      if ($urandom_range(99) < 85) begin
        if (mode == pls_pkg::MODE_INSERT)
          position = 5'($urandom_range(fill + 1, 1));
        else
          position = 5'($urandom_range((fill > 0) ? fill : LIST_DEPTH, 1));
      end else begin
        position = 5'($urandom_range(31, 0));
      end
      send_request(mode, random_value(), position);
    end
    calm     = 1'b0;
    in_valid <= 1'b0;

    // let the checker count the last transaction before watching it drain
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0 && results_outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
